// ===== design/brbf_pkg.sv =====
// Shared types and constants of the circular byte FIFO.
package brbf_pkg;

	// Field widths fixed by the interface.
	localparam int CMD_W  = 2;
	localparam int LEN_W  = 7;
	localparam int DATA_W = 64;
	localparam int CAP_W  = 11;
	localparam int STAT_W = 2;
	localparam int BYTE_W = 8;

	// Command codes. Any other code behaves as a query.
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_ARG   = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_RESP
	} state_t;

	// One result transaction.
	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              byte_valid;
		logic [LEN_W-1:0]  done_count;
		logic [CAP_W-1:0]  fill_level;
		logic [STAT_W-1:0] status;
		logic              last;
	} res_t;

	// Load request from the sequencer to the output register.
	typedef struct packed {
		logic load;
		res_t res;
	} out_ld_t;

endpackage

// ===== design/brbf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module brbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/brbf_seq.sv =====
// Command sequencer: pointers, fill count, status and byte store accesses.
module brbf_seq #(
	parameter int DEPTH       = 1024,
	parameter int WRITE_LANES = 8,
	parameter int MAX_READ    = 64,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [brbf_pkg::CAP_W-1:0]    cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [brbf_pkg::CMD_W-1:0]    cmd,
	input  logic [brbf_pkg::LEN_W-1:0]    length,
	input  logic [brbf_pkg::DATA_W-1:0]   write_data,
	input  logic                          buffer_given,
	input  logic                          out_free,
	output brbf_pkg::out_ld_t             out_ld,
	output logic                          mem_we,
	output logic [IW-1:0]                 mem_waddr,
	output logic [brbf_pkg::BYTE_W-1:0]   mem_wdata,
	output logic                          mem_re,
	output logic [IW-1:0]                 mem_raddr,
	input  logic [brbf_pkg::BYTE_W-1:0]   mem_rdata
);

	localparam int CAP_W  = brbf_pkg::CAP_W;
	localparam int LEN_W  = brbf_pkg::LEN_W;
	localparam int BYTE_W = brbf_pkg::BYTE_W;
	localparam int CW     = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;
	localparam int LIM    = (DEPTH > (2 ** CAP_W) - 1) ? (2 ** CAP_W) - 1 : DEPTH;
	localparam int LW     = $clog2(WRITE_LANES + 1);
	localparam int RW     = $clog2(MAX_READ + 1);
	localparam int CNT_W  = (LW > RW) ? LW : RW;
	localparam int DW     = WRITE_LANES * BYTE_W;

	localparam logic [CAP_W-1:0] LIM_C   = CAP_W'(LIM);
	localparam logic [CAP_W-1:0] LANES_C = CAP_W'(WRITE_LANES);
	localparam logic [CAP_W-1:0] MAXRD_C = CAP_W'(MAX_READ);

	brbf_pkg::state_t              state_q, state_d;
	logic [CAP_W-1:0]              cap_q;
	logic [IW-1:0]                 wr_idx_q, rd_idx_q;
	logic [CAP_W-1:0]              fill_q;
	logic [brbf_pkg::STAT_W-1:0]   last_st_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [DW-1:0]                 wdata_q;
	brbf_pkg::res_t                resp_q;
	logic                          pend_s1, last_s1;

	logic [CAP_W-1:0]              eff_cap, cfg_eff, len_c, free_c, want_c, rd_cnt_c;
	logic                          accept, issue;
	brbf_pkg::res_t                dec_res;
	brbf_pkg::state_t              dec_next;
	logic [CAP_W-1:0]              dec_fill;
	logic [brbf_pkg::STAT_W-1:0]   dec_st;
	logic [CNT_W-1:0]              dec_cnt;

	// Step a ring index, wrapping at the capacity in use.
	function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx,
			input logic [CAP_W-1:0] cap);
		logic [CW-1:0] inc;
		inc = CW'(idx) + CW'(1);
		return (inc >= CW'(cap)) ? '0 : inc[IW-1:0];
	endfunction

	// Effective capacity saturates at the store depth, or at the largest capacity value if that is smaller.
	assign eff_cap  = (cap_q > LIM_C) ? LIM_C : cap_q;
	assign cfg_eff  = (cfg_write_data > LIM_C) ? LIM_C : cfg_write_data;
	assign len_c    = CAP_W'(length);
	assign free_c   = eff_cap - fill_q;
	assign want_c   = (len_c > MAXRD_C) ? MAXRD_C : len_c;
	assign rd_cnt_c = (want_c < fill_q) ? want_c : fill_q;

	assign accept = in_valid && in_ready;
	assign issue  = (state_q == brbf_pkg::S_READ) && !pend_s1 && out_free && (cnt_q != '0);

	// Decode of an incoming transaction against the current FIFO state.
	always_comb begin
		dec_res            = '0;
		dec_res.last       = 1'b1;
		dec_next           = brbf_pkg::S_RESP;
		dec_fill           = fill_q;
		dec_st             = last_st_q;
		dec_cnt            = '0;
		case (cmd)
			brbf_pkg::CMD_WRITE, brbf_pkg::CMD_READ: begin
				if (eff_cap == '0) begin
					dec_st = brbf_pkg::ST_ARG;
				end else if (length == '0) begin
					dec_st = brbf_pkg::ST_OK;
				end else if (!buffer_given) begin
					dec_st = brbf_pkg::ST_ARG;
				end else if (cmd == brbf_pkg::CMD_WRITE) begin
					if (len_c > LANES_C || len_c > free_c) begin
						dec_st = brbf_pkg::ST_RANGE;
					end else begin
						dec_st             = brbf_pkg::ST_OK;
						dec_fill           = fill_q + len_c;
						dec_res.done_count = length;
						dec_next           = brbf_pkg::S_WRITE;
						dec_cnt            = CNT_W'(length);
					end
				end else begin
					dec_st             = brbf_pkg::ST_OK;
					dec_fill           = fill_q - rd_cnt_c;
					dec_res.done_count = LEN_W'(rd_cnt_c);
					if (rd_cnt_c != '0) begin
						dec_next = brbf_pkg::S_READ;
						dec_cnt  = CNT_W'(rd_cnt_c);
					end
				end
			end
			default: begin
				dec_st = last_st_q;
			end
		endcase
		dec_res.status     = dec_st;
		dec_res.fill_level = (eff_cap == '0) ? '0 : dec_fill;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			brbf_pkg::S_IDLE: begin
				if (accept) begin
					state_d = dec_next;
				end
			end
			brbf_pkg::S_WRITE: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = brbf_pkg::S_RESP;
				end
			end
			brbf_pkg::S_READ: begin
				if (pend_s1 && last_s1) begin
					state_d = brbf_pkg::S_IDLE;
				end
			end
			brbf_pkg::S_RESP: begin
				if (out_free) begin
					state_d = brbf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = brbf_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs: handshake, store accesses and result loads.
	always_comb begin
		in_ready  = (state_q == brbf_pkg::S_IDLE) && !cfg_write_en;
		mem_we    = (state_q == brbf_pkg::S_WRITE);
		mem_waddr = wr_idx_q;
		mem_wdata = wdata_q[BYTE_W-1:0];
		mem_re    = issue;
		mem_raddr = rd_idx_q;
		out_ld.load = pend_s1 || ((state_q == brbf_pkg::S_RESP) && out_free);
		out_ld.res  = resp_q;
		if (pend_s1) begin
			out_ld.res.read_byte  = mem_rdata;
			out_ld.res.byte_valid = 1'b1;
			out_ld.res.status     = brbf_pkg::ST_OK;
			out_ld.res.last       = last_s1;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= brbf_pkg::S_IDLE;
			cap_q     <= brbf_pkg::CAP_RESET;
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			fill_q    <= '0;
			last_st_q <= brbf_pkg::ST_OK;
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				cap_q     <= cfg_write_data;
				wr_idx_q  <= '0;
				rd_idx_q  <= '0;
				fill_q    <= '0;
				last_st_q <= (cfg_eff != '0) ? brbf_pkg::ST_OK : brbf_pkg::ST_ARG;
			end else if (accept) begin
				fill_q    <= dec_fill;
				last_st_q <= dec_st;
				cnt_q     <= dec_cnt;
			end else if (state_q == brbf_pkg::S_WRITE) begin
				wr_idx_q <= step_idx(wr_idx_q, eff_cap);
				cnt_q    <= cnt_q - CNT_W'(1);
			end else if (issue) begin
				rd_idx_q <= step_idx(rd_idx_q, eff_cap);
				cnt_q    <= cnt_q - CNT_W'(1);
			end
			// A read issued this cycle returns its byte in the next one.
			pend_s1 <= issue;
			if (issue) begin
				last_s1 <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// Payload held for the transaction in progress.
	always_ff @(posedge clk) begin
		if (accept) begin
			wdata_q <= write_data[DW-1:0];
			resp_q  <= dec_res;
		end else if (state_q == brbf_pkg::S_WRITE) begin
			wdata_q <= wdata_q >> BYTE_W;
		end
	end

endmodule

// ===== design/brbf_obuf.sv =====
// Output register that holds one result transaction until it is taken.
module brbf_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  brbf_pkg::out_ld_t out_ld,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output brbf_pkg::res_t    res
);

	logic           valid_q;
	brbf_pkg::res_t res_q;

	// The register may be refilled in the cycle it is emptied.
	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res       = res_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ld.load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_ld.load) begin
			res_q <= out_ld.res;
		end
	end

endmodule

// ===== design/byte_ring_buffer_fifo.sv =====
// Top level of the circular byte FIFO.
//
//  Channel   Handshake                     Payload
//  config    cfg_write_en                  cfg_write_data (capacity in use)
//  input     in_valid / in_ready           cmd, length, write_data, buffer_given
//  output    out_valid / out_ready         read_byte, byte_valid, done_count,
//                                          fill_level, status, last
//
// One transaction is in progress at a time. A query, an error or an empty read
// gives one result; a write of n bytes goes one byte a cycle through the single
// write port of the byte store. Each read byte is a registered store read that
// is loaded into the output register in the next cycle; the next store read
// waits for that load and for a free output register. Reset clears the pointers
// and the fill count at once; the store itself needs no clearing. A stalled
// output holds its result and the next input is taken while it waits.
module byte_ring_buffer_fifo #(
	parameter int DEPTH       = 1024,
	parameter int WRITE_LANES = 8,
	parameter int MAX_READ    = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [brbf_pkg::CAP_W-1:0]    cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [brbf_pkg::CMD_W-1:0]    cmd,
	input  logic [brbf_pkg::LEN_W-1:0]    length,
	input  logic [brbf_pkg::DATA_W-1:0]   write_data,
	input  logic                          buffer_given,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [brbf_pkg::BYTE_W-1:0]   read_byte,
	output logic                          byte_valid,
	output logic [brbf_pkg::LEN_W-1:0]    done_count,
	output logic [brbf_pkg::CAP_W-1:0]    fill_level,
	output logic [brbf_pkg::STAT_W-1:0]   status,
	output logic                          last
);

	localparam int IW = $clog2(DEPTH);

	brbf_pkg::out_ld_t           out_ld;
	brbf_pkg::res_t              res;
	logic                        out_free;
	logic                        mem_we, mem_re;
	logic [IW-1:0]               mem_waddr, mem_raddr;
	logic [brbf_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

	// Sequencer.
	brbf_seq #(
		.DEPTH       (DEPTH),
		.WRITE_LANES (WRITE_LANES),
		.MAX_READ    (MAX_READ)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.length         (length),
		.write_data     (write_data),
		.buffer_given   (buffer_given),
		.out_free       (out_free),
		.out_ld         (out_ld),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_re         (mem_re),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

	// Byte store.
	brbf_ram #(
		.WIDTH (brbf_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register.
	brbf_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.out_ld    (out_ld),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign read_byte  = res.read_byte;
	assign byte_valid = res.byte_valid;
	assign done_count = res.done_count;
	assign fill_level = res.fill_level;
	assign status     = res.status;
	assign last       = res.last;

endmodule

// ===== design/brbf_chk.sv =====
// Port-level checker for the circular byte FIFO, bound to the top level.
module brbf_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_write_en,
	input logic [brbf_pkg::CAP_W-1:0]    cfg_write_data,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [brbf_pkg::CMD_W-1:0]    cmd,
	input logic [brbf_pkg::LEN_W-1:0]    length,
	input logic [brbf_pkg::DATA_W-1:0]   write_data,
	input logic                          buffer_given,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [brbf_pkg::BYTE_W-1:0]   read_byte,
	input logic                          byte_valid,
	input logic [brbf_pkg::LEN_W-1:0]    done_count,
	input logic [brbf_pkg::CAP_W-1:0]    fill_level,
	input logic [brbf_pkg::STAT_W-1:0]   status,
	input logic                          last
);

	// A stalled result transaction is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_byte) &&
			$stable(byte_valid) && $stable(done_count) && $stable(fill_level) &&
			$stable(status) && $stable(last))
		else $error("result changed while stalled");

	// Only one input transaction is in progress at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a transaction is in progress");

	// A delivered byte always belongs to a successful read.
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> status == brbf_pkg::ST_OK && done_count != '0)
		else $error("byte result with bad status or count");

	// A result without a byte is the only result of its transaction.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last && read_byte == '0)
		else $error("byteless result not final or not zero");

	// While a read still has bytes to deliver, no new input is taken.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && byte_valid && !last |=> !in_ready)
		else $error("input accepted in the middle of a read");

endmodule

bind byte_ring_buffer_fifo brbf_chk u_chk (.*);

// ===== bench/tb_byte_ring_buffer_fifo.sv =====
// Self-checking testbench for the circular byte FIFO, with its own predictor and random idling.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_fifo;
	import brbf_pkg::*;

	localparam int STORE_DEPTH = 1024;
	localparam int LANES = 8;
	localparam int READ_LIMIT = 64;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int MAX_REPORTS = 40;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_REQUESTS = 60;

	// One request transaction as offered on the input channel.
	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [LEN_W-1:0]  length;
		logic [DATA_W-1:0] data;
		logic              given;
		bit                drain_first;
	} fifo_request_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write_en = 1'b0;
	logic [CAP_W-1:0]   cfg_write_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [CMD_W-1:0]   cmd = '0;
	logic [LEN_W-1:0]   length = '0;
	logic [DATA_W-1:0]  write_data = '0;
	logic               buffer_given = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [BYTE_W-1:0]  read_byte;
	logic               byte_valid;
	logic [LEN_W-1:0]   done_count;
	logic [CAP_W-1:0]   fill_level;
	logic [STAT_W-1:0]  status;
	logic               last;

	fifo_request_t pending_requests[$];
	fifo_request_t on_bus;
	res_t          awaited_responses[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int error_count = 0;
	int requests_taken = 0;
	int responses_checked = 0;
	int capacity_writes = 0;

	// Shadow copy of the FIFO state kept by the predictor.
	logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];
	logic [CAP_W-1:0]  shadow_cap = CAP_RESET;
	int unsigned       shadow_wr = 0;
	int unsigned       shadow_rd = 0;
	int unsigned       shadow_fill = 0;
	logic [STAT_W-1:0] shadow_status = ST_OK;

	byte_ring_buffer_fifo #(
		.DEPTH(STORE_DEPTH),
		.WRITE_LANES(LANES),
		.MAX_READ(READ_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.length(length),
		.write_data(write_data),
		.buffer_given(buffer_given),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_byte(read_byte),
		.byte_valid(byte_valid),
		.done_count(done_count),
		.fill_level(fill_level),
		.status(status),
		.last(last)
	);

	always #5 clk = ~clk;

	// Prints one line per mismatch, up to a limit, and counts every one.
	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("[%0t] MISMATCH: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [CAP_W-1:0] got,
			input logic [CAP_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Works out the responses to one accepted request and updates the shadow state.
	task automatic predict_fifo_response(input fifo_request_t rq);
		int unsigned usable;
		int unsigned count;
		int unsigned i;
		res_t r;
		usable = (shadow_cap > STORE_DEPTH) ? STORE_DEPTH : shadow_cap;
		r = '0;
		r.last = 1'b1;
		r.fill_level = CAP_W'(shadow_fill);
		if (rq.cmd != CMD_WRITE && rq.cmd != CMD_READ) begin
			// Queries, the unused code among them, change nothing.
			if (usable == 0) begin
				r.fill_level = '0;
			end
		end else if (usable == 0) begin
			shadow_status = ST_ARG;
			r.fill_level = '0;
		end else if (rq.length == 0) begin
			shadow_status = ST_OK;
		end else if (!rq.given) begin
			shadow_status = ST_ARG;
		end else if (rq.cmd == CMD_WRITE) begin
			if (rq.length > LANES || rq.length > usable - shadow_fill) begin
				shadow_status = ST_RANGE;
			end else begin
				for (i = 0; i < rq.length; i++) begin
					shadow_store[shadow_wr] = rq.data[8*i +: 8];
					shadow_wr = (shadow_wr + 1 >= usable) ? 0 : shadow_wr + 1;
				end
				shadow_fill += rq.length;
				r.done_count = rq.length;
				r.fill_level = CAP_W'(shadow_fill);
				shadow_status = ST_OK;
			end
		end else begin
			// A read is cut to the read limit and to the bytes held.
			count = (rq.length > READ_LIMIT) ? READ_LIMIT : rq.length;
			if (count > shadow_fill) begin
				count = shadow_fill;
			end
			shadow_status = ST_OK;
			if (count != 0) begin
				shadow_fill -= count;
				r.byte_valid = 1'b1;
				r.done_count = LEN_W'(count);
				r.fill_level = CAP_W'(shadow_fill);
				r.status = ST_OK;
				for (i = 0; i < count; i++) begin
					r.read_byte = shadow_store[shadow_rd];
					r.last = (i + 1 == count);
					awaited_responses.push_back(r);
					shadow_rd = (shadow_rd + 1 >= usable) ? 0 : shadow_rd + 1;
				end
				return;
			end
		end
		r.status = shadow_status;
		awaited_responses.push_back(r);
	endtask

	task automatic push_request(input logic [CMD_W-1:0] c, input int len,
			input logic [DATA_W-1:0] data, input logic given, input bit drain);
		fifo_request_t rq;
		rq.cmd = c;
		rq.length = LEN_W'(len);
		rq.data = data;
		rq.given = given;
		rq.drain_first = drain;
		pending_requests.push_back(rq);
	endtask

	// Mostly well-formed writes and reads with random content, with some noise.
	function automatic fifo_request_t random_request();
		fifo_request_t rq;
		int unsigned pick;
		pick = $urandom_range(99);
		rq.cmd = CMD_WRITE;
		rq.length = LEN_W'($urandom_range(1, LANES));
		rq.data = {$urandom, $urandom};
		rq.given = 1'b1;
		rq.drain_first = 1'b0;
		if (pick >= 45 && pick < 82) begin
			rq.cmd = CMD_READ;
			rq.length = ($urandom_range(9) != 0) ? LEN_W'($urandom_range(1, 12)) :
				LEN_W'($urandom_range(13, 64));
		end else if (pick >= 82 && pick < 90) begin
			rq.cmd = ($urandom_range(3) != 0) ? CMD_QUERY : CMD_SPARE;
		end else if (pick >= 90) begin
			rq.cmd = CMD_W'($urandom_range(3));
			rq.length = LEN_W'($urandom_range(127));
			rq.given = 1'($urandom_range(1));
		end
		return rq;
	endfunction

	// Waits until nothing is queued, offered or awaited, looking on the falling
	// edge so that the driver's latest updates are seen.
	task automatic wait_for_quiet();
		do begin
			@(negedge clk);
		end while (pending_requests.size() != 0 || in_valid ||
			awaited_responses.size() != 0);
	endtask

	// Writes the capacity register while the block is idle and clears the shadow pointers.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_for_quiet();
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		shadow_cap = value;
		shadow_wr = 0;
		shadow_rd = 0;
		shadow_fill = 0;
		shadow_status = (value != 0) ? ST_OK : ST_ARG;
		capacity_writes++;
	endtask

	// Driver: offers queued requests and predicts each accepted transaction.
	always @(posedge clk) begin
		bit take;
		bit go;
		take = arst_n && in_valid && in_ready;
		if (take) begin
			predict_fifo_response(on_bus);
			requests_taken++;
		end
		if (arst_n && (!in_valid || take)) begin
			go = pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct;
			if (go && pending_requests[0].drain_first && awaited_responses.size() != 0) begin
				go = 1'b0;
			end
			if (go) begin
				on_bus = pending_requests.pop_front();
				in_valid <= 1'b1;
				cmd <= on_bus.cmd;
				length <= on_bus.length;
				write_data <= on_bus.data;
				buffer_given <= on_bus.given;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted down one cycle at a time.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Monitor: compares each accepted response with the oldest one awaited.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_responses.size() == 0) begin
				report_mismatch("response transaction with none awaited");
			end else begin
				want = awaited_responses.pop_front();
				check_field("read_byte", CAP_W'(read_byte), CAP_W'(want.read_byte));
				check_field("byte_valid", CAP_W'(byte_valid), CAP_W'(want.byte_valid));
				check_field("done_count", CAP_W'(done_count), CAP_W'(want.done_count));
				check_field("fill_level", fill_level, want.fill_level);
				check_field("status", CAP_W'(status), CAP_W'(want.status));
				check_field("last", CAP_W'(last), CAP_W'(want.last));
			end
			responses_checked++;
		end
		out_ready <= arst_n && hold_cycles == 0 && $urandom_range(99) >= recv_stall_pct;
	end

	// Stimulus sequence.
	initial begin
		int ph;
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries after reset, zero length, missing buffer and a read of an empty FIFO.
		push_request(CMD_QUERY, 0, '0, 1'b0, 1'b0);
		push_request(CMD_SPARE, 127, '1, 1'b1, 1'b0);
		push_request(CMD_READ, 4, '0, 1'b1, 1'b0);
		push_request(CMD_WRITE, 0, '1, 1'b0, 1'b0);
		push_request(CMD_READ, 0, '0, 1'b0, 1'b0);
		push_request(CMD_WRITE, 3, '1, 1'b0, 1'b0);
		push_request(CMD_READ, 3, '0, 1'b0, 1'b0);

		// Fill past the read limit with full-width writes of marked patterns.
		push_request(CMD_WRITE, 8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
		push_request(CMD_WRITE, 8, 64'h0000_0000_0000_0000, 1'b1, 1'b0);
		push_request(CMD_WRITE, 8, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
		push_request(CMD_WRITE, 8, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0);
		push_request(CMD_WRITE, 8, 64'h5555_5555_5555_5555, 1'b1, 1'b0);
		push_request(CMD_WRITE, 8, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
		push_request(CMD_WRITE, 8, 64'h8040_2010_0804_0201, 1'b1, 1'b0);
		push_request(CMD_WRITE, 8, 64'h7FBF_DFEF_F7FB_FDFE, 1'b1, 1'b0);
		push_request(CMD_WRITE, 1, 64'h0000_0000_0000_00A5, 1'b1, 1'b0);

		// Writes wider than the lanes, then long reads cut to the limit and to the bytes held.
		push_request(CMD_WRITE, 9, '1, 1'b1, 1'b0);
		push_request(CMD_WRITE, 64, '1, 1'b1, 1'b0);
		push_request(CMD_QUERY, 0, '0, 1'b1, 1'b0);
		push_request(CMD_READ, 127, '0, 1'b1, 1'b0);
		push_request(CMD_READ, 64, '0, 1'b1, 1'b0);

		// Zero capacity makes every access an argument error.
		write_capacity(11'd0);
		push_request(CMD_WRITE, 8, '1, 1'b1, 1'b0);
		push_request(CMD_READ, 4, '0, 1'b1, 1'b0);
		push_request(CMD_QUERY, 0, '0, 1'b1, 1'b0);

		// Small capacity: a write exceeding the free space, then an exact fill.
		write_capacity(11'd7);
		push_request(CMD_WRITE, 5, 64'h0000_00EE_DDCC_BBAA, 1'b1, 1'b0);
		push_request(CMD_WRITE, 3, 64'h0000_0000_0011_2233, 1'b1, 1'b0);
		push_request(CMD_WRITE, 2, 64'h0000_0000_0000_9988, 1'b1, 1'b0);
		push_request(CMD_READ, 10, '0, 1'b1, 1'b0);

		// Back-pressure: the receiver holds off while the sender keeps offering,
		// and midway the sender waits for every awaited response.
		write_capacity(CAP_RESET);
		@(posedge clk);
		hold_cycles <= HOLD_OFF_CYCLES;
		for (n = 0; n < 40; n++) begin
			push_request(($urandom_range(9) < 7) ? CMD_WRITE : CMD_READ, $urandom_range(1, LANES),
				{$urandom, $urandom}, 1'b1, n == 20);
		end

		// Random phases over several capacities and idling patterns.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_capacity(11'd2047);
				1: write_capacity(11'd7);
				2: write_capacity(11'd1);
				default: write_capacity(CAP_W'($urandom_range(2, STORE_DEPTH)));
			endcase
			send_idle_pct <= (ph == 1) ? 52 : (ph == 3) ? 32 : 0;
			recv_stall_pct <= (ph == 2) ? 52 : (ph == 3) ? 32 : 0;
			for (n = 0; n < PHASE_REQUESTS; n++) begin
				pending_requests.push_back(random_request());
			end
		end

		wait_for_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_responses.size() != 0) begin
			report_mismatch($sformatf("%0d responses never arrived", awaited_responses.size()));
		end
		$display("Covered %0d request and %0d response transactions over %0d capacity settings,",
			requests_taken, responses_checked, capacity_writes);
		$display("with idle, stall and hold-off phases; %0d mismatches counted.", error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== byte_ring_buffer_fifo.f =====
design/brbf_pkg.sv
design/brbf_ram.sv
design/brbf_seq.sv
design/brbf_obuf.sv
design/byte_ring_buffer_fifo.sv
design/brbf_chk.sv
bench/tb_byte_ring_buffer_fifo.sv
